[sv/cdad_pkg.sv]
package cdad_pkg;

  // Field widths of the two channels.
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int OFFSET_W = 21;

  // Internal widths. Years and day numbers are carried with a positive bias so that
  // every floor division below works on non-negative values.
  localparam int YS_W   = 15;
  localparam int DN_W   = 24;
  localparam int PART_W = 22;
  localparam int NUM_W  = 32;
  localparam int REM_W  = 9;
  localparam int MI_W   = 4;
  localparam int C_W    = 9;

  localparam int unsigned ERA_DAYS = 146097;

  // Input years are lifted by one era (400 years); the day number is lifted by seven eras,
  // so the year estimate comes out 3200 years high.
  localparam logic [YS_W-1:0] YEAR_BIAS_IN = 15'd400;
  localparam logic [DN_W-1:0] DN_BIAS = 24'(7 * ERA_DAYS);
  localparam logic signed [YS_W:0] YEAR_BIAS_OUT = 16'sd3200;

  // (10000*n + 14780) / 3652425 reduces to (400*n + 591) / 146097 exactly.
  localparam logic [NUM_W-1:0] EST_SCALE = 32'd400;
  localparam logic [NUM_W-1:0] EST_ROUND = 32'd591;

  // Reciprocals: floor(2^40 / 146097), 5243 / 2^19 for /100, ceil(2^28 / 3060).
  localparam logic [22:0] EST_MUL    = 23'((64'd1 << 40) / 64'd146097);
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int          DIV100_SH  = 19;
  localparam logic [16:0] MI_MUL     = 17'((32'd268435456 + 32'd3059) / 32'd3060);
  localparam int          MI_SH      = 28;

  localparam logic [15:0] MI_SCALE = 16'd100;
  localparam logic [15:0] MI_ROUND = 16'd52;

  localparam logic signed [YS_W:0] YEAR_MIN = 16'sd1;
  localparam logic signed [YS_W:0] YEAR_MAX = 16'sd9999;

  typedef struct packed {
    logic [YEAR_W-1:0]          in_year;
    logic [MONTH_W-1:0]         in_month;
    logic [DAY_W-1:0]           in_day;
    logic signed [OFFSET_W-1:0] day_offset;
  } in_item_t;

  typedef logic [DN_W-1:0] daynum_t;

  typedef struct packed {
    logic [YS_W-1:0]  year_s;
    logic [REM_W-1:0] rem;
  } year_rem_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic               out_of_range;
  } date_t;

  // Month index counted from March: (month + 9) mod 12 for month 0..15.
  function automatic logic [MI_W-1:0] march_month(input logic [MONTH_W-1:0] month);
    logic [4:0] s;
    s = {1'b0, month} + 5'd9;
    if (s >= 5'd24) begin
      s = s - 5'd24;
    end else if (s >= 5'd12) begin
      s = s - 5'd12;
    end
    return s[MI_W-1:0];
  endfunction

  // Days from March 1 to the first of the given March-based month: (mi*306 + 5) / 10.
  function automatic logic [8:0] month_start(input logic [MI_W-1:0] mi);
    logic [8:0] d;
    unique case (mi)
      4'd0:  d = 9'd0;
      4'd1:  d = 9'd31;
      4'd2:  d = 9'd61;
      4'd3:  d = 9'd92;
      4'd4:  d = 9'd122;
      4'd5:  d = 9'd153;
      4'd6:  d = 9'd184;
      4'd7:  d = 9'd214;
      4'd8:  d = 9'd245;
      4'd9:  d = 9'd275;
      4'd10: d = 9'd306;
      4'd11: d = 9'd337;
      4'd12: d = 9'd367;
      4'd13: d = 9'd398;
      4'd14: d = 9'd428;
      4'd15: d = 9'd459;
    endcase
    return d;
  endfunction

  // floor(x / 100), exact for x below 43690.
  function automatic logic [C_W-1:0] div100(input logic [YS_W-1:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'(DIV100_MUL);
    return p[DIV100_SH +: C_W];
  endfunction

  // 365*y + y/4 - y/100 + y/400, given c = y/100.
  function automatic logic [DN_W-1:0] year_days(input logic [YS_W-1:0] y,
                                                 input logic [C_W-1:0] c);
    return 24'(y) * 24'd365 + 24'(y[YS_W-1:2]) - 24'(c) + 24'(c[C_W-1:2]);
  endfunction

endpackage

[sv/cdad_ifs.sv]
interface cdad_in_if;
  import cdad_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [YEAR_W-1:0]          in_year;
  logic [MONTH_W-1:0]         in_month;
  logic [DAY_W-1:0]           in_day;
  logic signed [OFFSET_W-1:0] day_offset;

  modport source (output valid, output in_year, output in_month, output in_day,
                  output day_offset, input ready);
  modport sink (input valid, input in_year, input in_month, input in_day,
                input day_offset, output ready);
endinterface

interface cdad_out_if;
  import cdad_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  out_year;
  logic [MONTH_W-1:0] out_month;
  logic [DAY_W-1:0]   out_day;
  logic               out_of_range;

  modport source (output valid, output out_year, output out_month, output out_day,
                  output out_of_range, input ready);
  modport sink (input valid, input out_year, input out_month, input out_day,
                input out_of_range, output ready);
endinterface

[sv/cdad_daynum.sv]
module cdad_daynum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cdad_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output cdad_pkg::daynum_t   out_daynum
);
  import cdad_pkg::*;

  localparam int STAGES = 3;

  logic [STAGES-1:0] v_r, v_nxt, adv;

  logic [MI_W-1:0]          m_mar;
  logic [YS_W-1:0]          yp_r, yp_nxt, yp2_r;
  logic signed [PART_W-1:0] part_r, part_nxt, part2_r;
  logic [C_W-1:0]           c_r, c_nxt;
  logic [DN_W-1:0]          dn_r, dn_nxt;

  always_comb begin
    adv[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt[0] = adv[0] ? in_valid : v_r[0];
    for (int k = 1; k < STAGES; k++) begin
      v_nxt[k] = adv[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // January and February belong to the year before.
  always_comb begin
    m_mar    = march_month(in_item.in_month);
    yp_nxt   = 15'(in_item.in_year) + YEAR_BIAS_IN - 15'(m_mar >= 4'd10);
    part_nxt = $signed({in_item.day_offset[OFFSET_W-1], in_item.day_offset})
             + $signed(22'(month_start(m_mar)))
             + $signed(22'(in_item.in_day)) - 22'sd1;
    c_nxt    = div100(yp_r);
    dn_nxt   = year_days(yp2_r, c_r) + DN_BIAS + 24'(part2_r);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      yp_r   <= yp_nxt;
      part_r <= part_nxt;
    end
    if (adv[1]) begin
      yp2_r   <= yp_r;
      part2_r <= part_r;
      c_r     <= c_nxt;
    end
    if (adv[2]) begin
      dn_r <= dn_nxt;
    end
  end

  assign in_ready   = adv[0];
  assign out_valid  = v_r[STAGES-1];
  assign out_daynum = dn_r;

endmodule

[sv/cdad_year_est.sv]
module cdad_year_est (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cdad_pkg::daynum_t    in_daynum,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cdad_pkg::year_rem_t  out_item
);
  import cdad_pkg::*;

  localparam int STAGES = 6;

  logic [STAGES-1:0] v_r, v_nxt, adv;

  logic [NUM_W-1:0] num_r, num_nxt, num2_r;
  logic [DN_W-1:0]  dn1_r, dn2_r, dn3_r, dn4_r, dn5_r;
  logic [46:0]      est_p;
  logic [YS_W-1:0]  q0_r, q0_nxt;
  logic [NUM_W-1:0] r;
  logic [YS_W-1:0]  q_r, q_nxt;
  logic [YS_W-1:0]  qa_r, qb_r, qa5_r, qb5_r, qb_nxt;
  logic [C_W-1:0]   ca_r, cb_r, ca_nxt, cb_nxt;
  logic [DN_W-1:0]  la_r, lb_r, la_nxt, lb_nxt;
  logic [DN_W-1:0]  rem_a, rem_b, rem_sel;
  logic [YS_W-1:0]  y_nxt;
  year_rem_t        item_r;

  always_comb begin
    adv[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt[0] = adv[0] ? in_valid : v_r[0];
    for (int k = 1; k < STAGES; k++) begin
      v_nxt[k] = adv[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // The estimate from the top numerator bits is at most one short; the remainder fixes it.
  always_comb begin
    num_nxt = 32'(in_daynum) * EST_SCALE + EST_ROUND;
    est_p   = 47'(num_r[NUM_W-1:8]) * 47'(EST_MUL);
    q0_nxt  = est_p[46:32];
    r       = num2_r - 32'(q0_r) * 32'(ERA_DAYS);
    q_nxt   = q0_r + 15'(r >= 32'(ERA_DAYS));
    qb_nxt  = q_r - 15'd1;
    ca_nxt  = div100(q_r);
    cb_nxt  = div100(qb_nxt);
    la_nxt  = year_days(qa_r, ca_r);
    lb_nxt  = year_days(qb_r, cb_r);
    rem_a   = dn5_r - la_r;
    rem_b   = dn5_r - lb_r;
    // A negative remainder means the year estimate was one too high.
    if (rem_a[DN_W-1]) begin
      rem_sel = rem_b;
      y_nxt   = qb5_r;
    end else begin
      rem_sel = rem_a;
      y_nxt   = qa5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      num_r <= num_nxt;
      dn1_r <= in_daynum;
    end
    if (adv[1]) begin
      q0_r   <= q0_nxt;
      num2_r <= num_r;
      dn2_r  <= dn1_r;
    end
    if (adv[2]) begin
      q_r   <= q_nxt;
      dn3_r <= dn2_r;
    end
    if (adv[3]) begin
      qa_r  <= q_r;
      qb_r  <= qb_nxt;
      ca_r  <= ca_nxt;
      cb_r  <= cb_nxt;
      dn4_r <= dn3_r;
    end
    if (adv[4]) begin
      la_r  <= la_nxt;
      lb_r  <= lb_nxt;
      qa5_r <= qa_r;
      qb5_r <= qb_r;
      dn5_r <= dn4_r;
    end
    if (adv[5]) begin
      item_r.year_s <= y_nxt;
      item_r.rem    <= rem_sel[REM_W-1:0];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[STAGES-1];
  assign out_item  = item_r;

  a_est_within_one: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> r < 32'(2 * ERA_DAYS))
    else $error("year estimate more than one era-day quotient short");

  a_rem_in_year: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> rem_sel < 24'd366)
    else $error("day within year out of range after correction");

endmodule

[sv/cdad_to_date.sv]
module cdad_to_date (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cdad_pkg::year_rem_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cdad_pkg::date_t      out_date
);
  import cdad_pkg::*;

  localparam int STAGES = 2;

  logic [STAGES-1:0] v_r, v_nxt, adv;

  logic [15:0]              x;
  logic [32:0]              mi_p;
  logic [MI_W-1:0]          mi_r, mi_nxt;
  logic [REM_W-1:0]         rem_r;
  logic [YS_W-1:0]          ys_r;
  logic [8:0]               dd;
  logic                     yc;
  logic [MONTH_W-1:0]       mm;
  logic signed [YS_W:0]     yt;
  logic                     oor;
  date_t                    date_r, date_nxt;

  always_comb begin
    adv[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt[0] = adv[0] ? in_valid : v_r[0];
    for (int k = 1; k < STAGES; k++) begin
      v_nxt[k] = adv[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    x      = 16'(in_item.rem) * MI_SCALE + MI_ROUND;
    mi_p   = 33'(x) * 33'(MI_MUL);
    mi_nxt = mi_p[MI_SH +: MI_W];

    // March-based months ten and eleven are January and February of the next year.
    yc = (mi_r >= 4'd10);
    if (yc) begin
      mm = mi_r - 4'd9;
    end else begin
      mm = mi_r + 4'd3;
    end
    dd  = 9'(rem_r) - month_start(mi_r) + 9'd1;
    yt  = $signed({1'b0, ys_r}) - YEAR_BIAS_OUT + $signed({15'd0, yc});
    oor = (yt < YEAR_MIN) || (yt > YEAR_MAX);

    if (oor) begin
      date_nxt = '{out_year: '0, out_month: '0, out_day: '0, out_of_range: 1'b1};
    end else begin
      date_nxt = '{out_year: yt[YEAR_W-1:0], out_month: mm, out_day: dd[DAY_W-1:0],
                   out_of_range: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      mi_r  <= mi_nxt;
      rem_r <= in_item.rem;
      ys_r  <= in_item.year_s;
    end
    if (adv[1]) begin
      date_r <= date_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[STAGES-1];
  assign out_date  = date_r;

  a_real_date: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && !date_r.out_of_range |->
      date_r.out_month >= 4'd1 && date_r.out_month <= 4'd12 && date_r.out_day != 5'd0)
    else $error("in-range result is not a calendar date");

  a_zero_when_oor: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && adv[1] && oor |=> date_r.out_year == '0 && date_r.out_month == '0)
    else $error("out-of-range result carries a non-zero date");

endmodule

[sv/calendar_date_add_days_unit.sv]
// Channel  Dir  Fields                                         Handshake
// in_ch    in   in_year, in_month, in_day, day_offset          valid / ready
// out_ch   out  out_year, out_month, out_day, out_of_range     valid / ready
//
// One transaction per cycle while out_ch accepts results. Each result passes through the
// eleven register stages: three build the day number, six estimate and correct the year,
// two split the remainder into month and day.
// Reset clears only the stage valid bits.
// When out_ch stalls the output stage holds; earlier stages keep filling empty slots,
// and in_ch.ready falls only once every stage holds a transaction.
module calendar_date_add_days_unit (
  input  logic        clk,
  input  logic        rst_n,
  cdad_in_if.sink     in_ch,
  cdad_out_if.source  out_ch
);
  import cdad_pkg::*;

  in_item_t  in_item;
  logic      dn_valid, dn_ready;
  daynum_t   dn;
  logic      yr_valid, yr_ready;
  year_rem_t yr;
  date_t     date;

  assign in_item = '{in_year: in_ch.in_year, in_month: in_ch.in_month,
                     in_day: in_ch.in_day, day_offset: in_ch.day_offset};

  cdad_daynum u_daynum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .out_valid  (dn_valid),
    .out_ready  (dn_ready),
    .out_daynum (dn)
  );

  cdad_year_est u_year_est (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dn_valid),
    .in_ready  (dn_ready),
    .in_daynum (dn),
    .out_valid (yr_valid),
    .out_ready (yr_ready),
    .out_item  (yr)
  );

  cdad_to_date u_to_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (yr_valid),
    .in_ready  (yr_ready),
    .in_item   (yr),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_date  (date)
  );

  assign out_ch.out_year     = date.out_year;
  assign out_ch.out_month    = date.out_month;
  assign out_ch.out_day      = date.out_day;
  assign out_ch.out_of_range = date.out_of_range;

endmodule

[sim/tb_calendar_date_add_days_unit.sv]
module tb_calendar_date_add_days_unit;
  import cdad_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 24;
  localparam int CHUNK_ITEMS = 105;

  logic clk;
  logic rst_n;

  cdad_in_if  in_ch ();
  cdad_out_if out_ch ();

  calendar_date_add_days_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  in_item_t   pending_items[$];
  date_t      expected_dates[$];
  idle_mode_e mode;
  int         items_issued;
  int         items_accepted;
  int         results_checked;
  int         range_flags_seen;
  int         error_count;
  int         quiet_cycles;
  int         hold_left;
  bit         hold_request;
  bit         hold_done;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic longint div_floor(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic longint mod_floor(input longint a, input longint b);
    longint r;
    r = a % b;
    if (r < 0) begin
      r = r + b;
    end
    return r;
  endfunction

  // Days in the years before y, counted from the start of the proleptic calendar.
  function automatic longint cumulative_days(input longint y);
    return 365 * y + div_floor(y, 4) - div_floor(y, 100) + div_floor(y, 400);
  endfunction

  function automatic date_t shifted_date(input in_item_t it);
    longint yr, mar, n, rem, mi, mm, dd;
    date_t  res;
    // The year is taken to begin on March 1, so January and February belong to the one before.
    mar = mod_floor(longint'(it.in_month) + 9, 12);
    yr  = longint'(it.in_year) - div_floor(mar, 10);
    n   = cumulative_days(yr) + div_floor(mar * 306 + 5, 10) + longint'(it.in_day) - 1
          + longint'($signed(it.day_offset));
    yr  = div_floor(10000 * n + 14780, 3652425);
    rem = n - cumulative_days(yr);
    if (rem < 0) begin
      yr  = yr - 1;
      rem = n - cumulative_days(yr);
    end
    mi = div_floor(100 * rem + 52, 3060);
    mm = mod_floor(mi + 2, 12) + 1;
    yr = yr + div_floor(mi + 2, 12);
    dd = rem - div_floor(mi * 306 + 5, 10) + 1;
    if (yr < 1 || yr > 9999) begin
      res = '0;
      res.out_of_range = 1'b1;
    end else begin
      res.out_year     = YEAR_W'(yr);
      res.out_month    = MONTH_W'(mm);
      res.out_day      = DAY_W'(dd);
      res.out_of_range = 1'b0;
    end
    return res;
  endfunction

  function automatic int month_length(input int y, input int m);
    bit leap;
    leap = (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    case (m)
      2: begin
        return leap ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  function automatic int sender_idle_pct(input idle_mode_e md);
    return (md == IDLE_SENDER) ? 58 : (md == IDLE_BOTH) ? 6 : 0;
  endfunction

  function automatic int receiver_stall_pct(input idle_mode_e md);
    return (md == IDLE_RECEIVER) ? 58 : (md == IDLE_BOTH) ? 6 : 0;
  endfunction

  task automatic add_item(input int y, input int m, input int d, input int off);
    in_item_t it;
    it.in_year    = YEAR_W'(y);
    it.in_month   = MONTH_W'(m);
    it.in_day     = DAY_W'(d);
    it.day_offset = OFFSET_W'(off);
    pending_items.push_back(it);
  endtask

  // Mostly real dates with offsets of assorted sizes; the rest uses the full field widths.
  task automatic add_random_item();
    int y, m, d, off, kind;
    kind = $urandom_range(9, 0);
    if (kind < 2) begin
      add_item($urandom_range(16383, 0), $urandom_range(15, 0), $urandom_range(31, 0),
               $urandom_range(2097151, 0));
    end else begin
      case ($urandom_range(3, 0))
        0: y = $urandom_range(30, 1);
        1: y = $urandom_range(9999, 9970);
        default: y = $urandom_range(9999, 1);
      endcase
      m = $urandom_range(12, 1);
      d = $urandom_range(month_length(y, m), 1);
      case (kind)
        2, 3: off = $urandom_range(800, 0) - 400;
        4: begin
          d   = ($urandom_range(1, 0) != 0) ? month_length(y, m) : 1;
          off = $urandom_range(6, 0) - 3;
        end
        5, 6: off = $urandom_range(80000, 0) - 40000;
        default: off = $urandom_range(2097151, 0);
      endcase
      add_item(y, m, d, off);
    end
  endtask

  task automatic wait_for_pending_drained();
    while (pending_items.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Sender: a new transaction goes on the bus only once the previous one has been taken.
  always @(negedge clk) begin
    in_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (items_issued == items_accepted) begin
      if (pending_items.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct(mode)) begin
        nxt = pending_items.pop_front();
        in_ch.in_year    <= nxt.in_year;
        in_ch.in_month   <= nxt.in_month;
        in_ch.in_day     <= nxt.in_day;
        in_ch.day_offset <= nxt.day_offset;
        in_ch.valid      <= 1'b1;
        items_issued     <= items_issued + 1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off on request so that the pipeline fills and stalls its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= receiver_stall_pct(mode));
    end
  end

  always @(posedge clk) begin
    in_item_t taken;
    date_t    got;
    date_t    want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        taken.in_year    = in_ch.in_year;
        taken.in_month   = in_ch.in_month;
        taken.in_day     = in_ch.in_day;
        taken.day_offset = in_ch.day_offset;
        expected_dates.push_back(shifted_date(taken));
        items_accepted = items_accepted + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.out_year     = out_ch.out_year;
        got.out_month    = out_ch.out_month;
        got.out_day      = out_ch.out_day;
        got.out_of_range = out_ch.out_of_range;
        if (expected_dates.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= 10) begin
            $display("error: result %0d/%0d/%0d flag %0b arrived with nothing expected",
                     got.out_year, got.out_month, got.out_day, got.out_of_range);
          end
        end else begin
          want = expected_dates.pop_front();
          results_checked = results_checked + 1;
          if (got.out_of_range) begin
            range_flags_seen = range_flags_seen + 1;
          end
          if (got.out_year !== want.out_year || got.out_month !== want.out_month ||
              got.out_day !== want.out_day || got.out_of_range !== want.out_of_range) begin
            error_count = error_count + 1;
            if (error_count <= 10) begin
              $display("error: result %0d expected %0d/%0d/%0d flag %0b, got %0d/%0d/%0d flag %0b",
                       results_checked, want.out_year, want.out_month, want.out_day,
                       want.out_of_range, got.out_year, got.out_month, got.out_day,
                       got.out_of_range);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    mode             = IDLE_NONE;
    items_issued     = 0;
    items_accepted   = 0;
    results_checked  = 0;
    range_flags_seen = 0;
    error_count      = 0;
    quiet_cycles     = 0;
    hold_left        = 0;
    hold_request     = 1'b0;
    hold_done        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.in_year    = '0;
    in_ch.in_month   = '0;
    in_ch.in_day     = '0;
    in_ch.day_offset = '0;
    out_ch.ready     = 1'b0;

    // Calendar limits, leap years, offset extremes and out-of-calendar field values.
    add_item(1, 1, 1, 0);
    add_item(1, 1, 1, -1);
    add_item(9999, 12, 31, 0);
    add_item(9999, 12, 31, 1);
    add_item(1, 1, 1, 1048575);
    add_item(9999, 12, 31, -1048576);
    add_item(2000, 2, 28, 1);
    add_item(1900, 2, 28, 1);
    add_item(2000, 2, 29, 365);
    add_item(2024, 3, 1, -1);
    add_item(2023, 12, 31, 1);
    add_item(2023, 0, 15, 0);
    add_item(2023, 13, 1, 0);
    add_item(2023, 14, 29, 0);
    add_item(2023, 15, 31, 0);
    add_item(2023, 5, 0, 0);
    add_item(2023, 2, 31, 0);
    add_item(2023, 4, 31, 0);
    add_item(0, 3, 1, 400);
    add_item(0, 0, 0, 0);
    add_item(10000, 1, 1, -1048576);
    add_item(16383, 15, 31, 1048575);
    add_item(16383, 6, 15, -1048576);
    add_item(1600, 2, 29, -2097152 / 2);
    add_item(4321, 10, 21, 699050);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait_for_pending_drained();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: mode = IDLE_SENDER;
        1: mode = IDLE_RECEIVER;
        2: mode = IDLE_BOTH;
        3: begin
          mode = IDLE_NONE;
          hold_request = 1'b1;
        end
        4: mode = IDLE_RECEIVER;
        default: mode = IDLE_SENDER;
      endcase
      repeat (CHUNK_ITEMS) add_random_item();
      wait_for_pending_drained();
    end

    while (items_issued != items_accepted || expected_dates.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_dates.size() != 0) begin
      error_count = error_count + expected_dates.size();
      $display("error: %0d results never arrived", expected_dates.size());
    end
    $display("Checked %0d dates from %0d transactions, %0d of them outside the year range,",
             results_checked, items_accepted, range_flags_seen);
    $display("under four idling patterns and one long output hold-off; %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
